/* src/lprd_pkg.sv */
package lprd_pkg;

   // decoder phase, one-hot
   typedef enum logic [4:0] {
      PH_HDR_HI    = 5'b00001,
      PH_HDR_LO    = 5'b00010,
      PH_CODE      = 5'b00100,
      PH_LITERAL   = 5'b01000,
      PH_RUN_VALUE = 5'b10000
   } phase_type;

   // code byte with this bit set opens a run
   localparam int unsigned RUN_FLAG_BIT = 7;

   // run repeat count is RUN_BASE minus the code byte
   localparam logic [8:0] RUN_BASE = 9'd257;

   // largest repeat count a result can carry
   localparam logic [7:0] MAX_REPEAT = 8'd129;

   // one decoded result
   typedef struct packed {
      logic [7:0] value;
      logic [7:0] count;
      logic       last;
   } result_type;

endpackage

/* src/lprd_decode.sv */
module lprd_decode
   import lprd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] in_byte,
   output logic       emit,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [14:0] len_ff, len_in;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  lit_ff, lit_in;

   logic [14:0] len_new;
   logic [15:0] pos_inc;
   logic        past_end;
   logic [15:0] left;
   logic [8:0]  code_len;
   logic [7:0]  run_count;
   logic [7:0]  lit_dec;
   logic        lit_last;

   // shared arithmetic of the body walk
   always_comb begin
      len_new   = len_ff | {7'd0, in_byte};
      pos_inc   = pos_ff + 16'd1;
      past_end  = pos_inc >= {1'b0, len_ff};
      left      = past_end ? 16'd0 : ({1'b0, len_ff} - pos_inc);
      code_len  = {1'b0, in_byte} + 9'd1;
      run_count = 8'(RUN_BASE - {1'b0, in_byte});
      lit_dec   = lit_ff - 8'd1;
      lit_last  = (lit_dec == 8'd0) && past_end;
   end

   // next state and result for the current byte
   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      lit_in   = lit_ff;
      emit     = 1'b0;
      result   = '{value: in_byte, count: 8'd1, last: 1'b0};
      case (phase_ff)
         PH_HDR_LO: begin
            len_in = len_new;
            pos_in = 16'd0;
            lit_in = 8'd0;
            if (len_new == 15'd0) begin
               // empty body: end marker only
               phase_in = PH_HDR_HI;
               emit     = 1'b1;
               result   = '{value: 8'd0, count: 8'd0, last: 1'b1};
            end else begin
               phase_in = PH_CODE;
            end
         end
         PH_CODE: begin
            pos_in = pos_inc;
            if (!in_byte[RUN_FLAG_BIT]) begin
               if (left == 16'd0) begin
                  // literal clipped to nothing at the end of the body
                  phase_in = PH_HDR_HI;
                  emit     = 1'b1;
                  result   = '{value: 8'd0, count: 8'd0, last: 1'b1};
               end else begin
                  lit_in   = (left < {7'd0, code_len}) ? left[7:0] : code_len[7:0];
                  phase_in = PH_LITERAL;
               end
            end else begin
               lit_in   = run_count;
               phase_in = PH_RUN_VALUE;
            end
         end
         PH_LITERAL: begin
            pos_in = pos_inc;
            lit_in = lit_dec;
            emit   = 1'b1;
            result = '{value: in_byte, count: 8'd1, last: lit_last};
            if (lit_dec == 8'd0) begin
               phase_in = lit_last ? PH_HDR_HI : PH_CODE;
            end
         end
         PH_RUN_VALUE: begin
            pos_in   = pos_inc;
            lit_in   = 8'd0;
            emit     = 1'b1;
            result   = '{value: in_byte, count: lit_ff, last: past_end};
            phase_in = past_end ? PH_HDR_HI : PH_CODE;
         end
         default: begin
            // header high byte, top bit dropped
            len_in   = {in_byte[6:0], 8'h00};
            pos_in   = 16'd0;
            lit_in   = 8'd0;
            phase_in = PH_HDR_LO;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR_HI;
         len_ff   <= 15'd0;
         pos_ff   <= 16'd0;
         lit_ff   <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         lit_ff   <= lit_in;
      end
   end

endmodule

/* src/length_prefixed_rle_decoder.sv */
// Length-prefixed run-length decoder.
// Request channel (req_valid / req_ready / req_in_byte) takes one compressed
// byte per request: two header bytes giving the body length (big-endian, top
// bit ignored), then code bytes with their literal or run value bytes.
// Result channel (rsp_valid / rsp_ready) returns zero or one result per
// request: rsp_out_value with rsp_repeat_count (1 for literal bytes, 2..129
// for runs, 0 for an end marker without data) and rsp_block_end on the last
// result of a block. After block end the next byte is a new header.
// A taken request waits in the input register until the result register is
// empty or being drained; the decode logic sits between the input register
// and the result register. Throughput: one request per cycle while the
// result register is empty or being drained.
// req_ready stays high while the result register is empty or being drained,
// so a stalled receiver holds one result and one pending request; the
// request side stops only once both are full.
// Reset clears both registers and returns the decoder to expect a header.
module length_prefixed_rle_decoder
   import lprd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_value,
   output logic [7:0] rsp_repeat_count,
   output logic       rsp_block_end
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   logic       out_free;
   logic       step;
   logic       emit;
   result_type result;

   // pipeline advance control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   // decode step
   lprd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (in_byte_ff),
      .emit    (emit),
      .result  (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_value    = rsp_ff.value;
   assign rsp_repeat_count = rsp_ff.count;
   assign rsp_block_end    = rsp_ff.last;

   // an empty result register never blocks requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   // a zero repeat count only comes as an end marker
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_repeat_count == 8'd0) |-> rsp_block_end)
      else $error("zero repeat count without block end");

   // repeat count never exceeds the largest run count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_repeat_count <= MAX_REPEAT))
      else $error("repeat count out of range");

   // a held result is not overwritten by the decode step
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_ff)))
      else $error("held result changed");

endmodule
